// File: hw/rtl/fbbc_pkg.sv
package fbbc_pkg;

   localparam int unsigned ENTRIES_DEFAULT = 64;
   localparam int unsigned KEY_W           = 128;
   localparam int unsigned SIZE_W          = 28;
   localparam int unsigned HANDLE_W        = 32;
   localparam int unsigned LIMIT_W         = 32;
   localparam int unsigned TOTAL_W         = 33;
   localparam int unsigned OUT_CNT_W       = 7;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd104857600;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_FULLDROP,
      ST_APPEND,
      ST_EVICT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [KEY_W-1:0]    key;
      logic [SIZE_W-1:0]   size;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

// File: hw/rtl/fifo_byte_budget_cache.sv
// steps: a lookup, a hit or a no-op insert runs MATCH then DONE; a new-key insert
// runs MATCH, FULLDROP if full (counted as an eviction), APPEND, EVICT walk, DONE
// throughput: one transaction at a time, set by the one-entry-per-cycle eviction
// walk that shifts the cell chain toward the oldest end
// reset: synchronous, clears all cell valid bits, the entry count and the byte total;
// byte_limit returns to 104857600, no clearing pass is needed
module fifo_byte_budget_cache #(
   parameter int unsigned ENTRIES = fbbc_pkg::ENTRIES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // key_hi, key_lo, entry_size, entry_handle, decode_ok
   input  logic [191:0]  req_tdata,
   // mode
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // hit, found_handle, evicted_count, total_bytes, entry_count
   output logic [79:0]   rsp_tdata,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [31:0]   csr_wdata
);

   localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
   localparam int unsigned EV_W  = $clog2(ENTRIES + 2);

   fbbc_pkg::state_type state_ff, state_in;

   logic                              mode_ff, ok_ff;
   logic [fbbc_pkg::KEY_W-1:0]        key_ff;
   logic [fbbc_pkg::SIZE_W-1:0]       size_ff;
   logic [fbbc_pkg::HANDLE_W-1:0]     handle_ff;
   logic                              hit_ff;
   logic [fbbc_pkg::HANDLE_W-1:0]     found_ff;
   logic [EV_W-1:0]                   evict_ff;
   logic [fbbc_pkg::TOTAL_W-1:0]      total_ff;
   logic [CNT_W-1:0]                  count_ff;
   logic [fbbc_pkg::LIMIT_W-1:0]      limit_ff;
   logic                              rsp_valid_ff;
   logic [79:0]                       rsp_data_ff;

   fbbc_pkg::entry_type               entries [ENTRIES];
   fbbc_pkg::entry_type               new_entry;
   logic [ENTRIES-1:0]                match_vec;
   logic [ENTRIES-1:0]                valid_vec;
   logic [fbbc_pkg::HANDLE_W-1:0]     match_handle;
   logic                              any_match;

   logic accept, do_shift, do_append, over, rsp_load, miss_insert;
   logic [CNT_W+6:0] cnt_wide;
   logic [EV_W+6:0]  ev_wide;

   assign new_entry = '{valid: 1'b1, key: key_ff, size: size_ff, handle: handle_ff};

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      fbbc_pkg::cell_ctl_type ctl;
      fbbc_pkg::entry_type    nbr;
      if (i == ENTRIES - 1) begin : g_last
         assign nbr = '0;
      end else begin : g_mid
         assign nbr = entries[i+1];
      end
      assign ctl.shift = do_shift;
      assign ctl.load  = do_append && (count_ff[IDX_W-1:0] == IDX_W'(i));
      fbbc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .nbr        (nbr),
         .new_entry  (new_entry),
         .search_key (key_ff),
         .entry      (entries[i]),
         .match      (match_vec[i])
      );
      assign valid_vec[i] = entries[i].valid;
   end

   always_comb begin
      match_handle = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match_handle = match_handle | (match_vec[i] ? entries[i].handle : '0);
      end
   end

   assign any_match   = |match_vec;
   assign accept      = req_tvalid && req_tready;
   assign over        = total_ff >= {1'b0, limit_ff};
   assign miss_insert = (mode_ff == fbbc_pkg::MODE_INSERT) && ok_ff && !any_match;
   assign rsp_load    = (state_ff == fbbc_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fbbc_pkg::ST_IDLE:     if (accept) state_in = fbbc_pkg::ST_MATCH;
         fbbc_pkg::ST_MATCH: begin
            if (!miss_insert) begin
               state_in = fbbc_pkg::ST_DONE;
            end else if (count_ff == CNT_W'(ENTRIES)) begin
               state_in = fbbc_pkg::ST_FULLDROP;
            end else begin
               state_in = fbbc_pkg::ST_APPEND;
            end
         end
         fbbc_pkg::ST_FULLDROP: state_in = fbbc_pkg::ST_APPEND;
         fbbc_pkg::ST_APPEND:   state_in = fbbc_pkg::ST_EVICT;
         fbbc_pkg::ST_EVICT:    if (!(over && count_ff != '0)) state_in = fbbc_pkg::ST_DONE;
         fbbc_pkg::ST_DONE:     if (rsp_load) state_in = fbbc_pkg::ST_IDLE;
         default:               state_in = fbbc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_tready = 1'b0;
      do_shift   = 1'b0;
      do_append  = 1'b0;
      case (state_ff)
         fbbc_pkg::ST_IDLE:     req_tready = 1'b1;
         fbbc_pkg::ST_FULLDROP: do_shift   = 1'b1;
         fbbc_pkg::ST_APPEND:   do_append  = 1'b1;
         fbbc_pkg::ST_EVICT:    do_shift   = over && (count_ff != '0);
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fbbc_pkg::ST_IDLE;
         total_ff     <= '0;
         count_ff     <= '0;
         limit_ff     <= fbbc_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) limit_ff <= csr_wdata;
         if (do_shift) begin
            total_ff <= total_ff - fbbc_pkg::TOTAL_W'(entries[0].size);
            count_ff <= count_ff - 1'b1;
         end else if (do_append) begin
            total_ff <= total_ff + fbbc_pkg::TOTAL_W'(size_ff);
            count_ff <= count_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign cnt_wide = {7'd0, count_ff};
   assign ev_wide  = {7'd0, evict_ff};

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_tuser;
         key_ff    <= {req_tdata[127:64], req_tdata[63:0]};
         size_ff   <= req_tdata[155:128];
         handle_ff <= req_tdata[187:156];
         ok_ff     <= req_tdata[188];
         evict_ff  <= '0;
      end else if (do_shift) begin
         evict_ff  <= evict_ff + 1'b1;
      end
      if (state_ff == fbbc_pkg::ST_MATCH) begin
         if (mode_ff == fbbc_pkg::MODE_LOOKUP || ok_ff) begin
            hit_ff   <= any_match;
            found_ff <= match_handle;
         end else begin
            hit_ff   <= 1'b0;
            found_ff <= '0;
         end
      end
      if (rsp_load) begin
         rsp_data_ff <= {cnt_wide[6:0], total_ff, ev_wide[6:0], found_ff, hit_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count above capacity");

   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("valid cells disagree with entry count");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      do_append |-> count_ff < CNT_W'(ENTRIES))
      else $error("append into a full chain");

   a_empty_total: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> total_ff == '0)
      else $error("empty cache with nonzero byte total");

endmodule

// File: hw/rtl/fbbc_cell.sv
module fbbc_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  fbbc_pkg::cell_ctl_type             ctl,
   input  fbbc_pkg::entry_type                nbr,
   input  fbbc_pkg::entry_type                new_entry,
   input  logic [fbbc_pkg::KEY_W-1:0]         search_key,
   output fbbc_pkg::entry_type                entry,
   output logic                               match
);

   fbbc_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = nbr;
      end else if (ctl.load) begin
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;
   assign match = entry_ff.valid && (entry_ff.key == search_key);

endmodule

// File: dv/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned NSLOT = fbbc_pkg::ENTRIES_DEFAULT;
   localparam int unsigned IDLE_LIMIT = 20000;

   typedef struct packed {
      logic        mode;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
      logic [27:0] entry_size;
      logic [31:0] entry_handle;
      logic        decode_ok;
   } cache_req_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] found_handle;
      logic [6:0]  evicted_count;
      logic [32:0] total_bytes;
      logic [6:0]  entry_count;
   } cache_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [191:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [31:0]  csr_wdata = '0;

   fifo_byte_budget_cache u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // shadow copy of the cache
   logic [31:0]  sh_limit;
   logic [63:0]  sh_hi [NSLOT];
   logic [63:0]  sh_lo [NSLOT];
   logic         sh_valid [NSLOT];
   logic [27:0]  sh_size [NSLOT];
   logic [31:0]  sh_handle [NSLOT];
   int unsigned  sh_ring [NSLOT];
   int unsigned  sh_head;
   int unsigned  sh_count;
   logic [32:0]  sh_total;

   cache_req_type pending_reqs[$];
   cache_rsp_type expected_rsps[$];
   logic [63:0]  used_his[$];
   logic [63:0]  used_los[$];
   bit           failed = 1'b0;
   bit           no_idle = 1'b0;
   bit           hold_req = 1'b0;
   int unsigned  idle_cycles = 0;

   function automatic int find_slot(logic [63:0] hi, logic [63:0] lo);
      for (int i = 0; i < NSLOT; i++)
         if (sh_valid[i] && sh_hi[i] == hi && sh_lo[i] == lo) return i;
      return -1;
   endfunction

   function automatic void drop_oldest();
      int unsigned s;
      s = sh_ring[sh_head];
      sh_total = sh_total - sh_size[s];
      sh_valid[s] = 1'b0;
      sh_head = (sh_head + 1) % NSLOT;
      sh_count--;
   endfunction

   function automatic cache_rsp_type predict_cache(cache_req_type r);
      cache_rsp_type o;
      int idx;
      int unsigned slot;
      int unsigned ev;
      o = '0;
      ev = 0;
      if (r.mode == fbbc_pkg::MODE_LOOKUP || r.decode_ok) begin
         idx = find_slot(r.key_hi, r.key_lo);
         if (idx >= 0) begin
            o.hit = 1'b1;
            o.found_handle = sh_handle[idx];
         end else if (r.mode == fbbc_pkg::MODE_INSERT) begin
            if (sh_count >= NSLOT) begin
               drop_oldest();
               ev++;
            end
            slot = 0;
            while (slot < NSLOT - 1 && sh_valid[slot]) slot++;
            sh_valid[slot] = 1'b1;
            sh_hi[slot] = r.key_hi;
            sh_lo[slot] = r.key_lo;
            sh_size[slot] = r.entry_size;
            sh_handle[slot] = r.entry_handle;
            sh_ring[(sh_head + sh_count) % NSLOT] = slot;
            sh_count++;
            sh_total = sh_total + r.entry_size;
            while ({1'b0, sh_total} >= {2'b0, sh_limit} && sh_count > 0) begin
               drop_oldest();
               ev++;
            end
         end
      end
      o.evicted_count = ev[6:0];
      o.total_bytes = sh_total;
      o.entry_count = sh_count[6:0];
      return o;
   endfunction

   function automatic bit roll_idle();
      return !no_idle && ($urandom_range(99) < 23);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(predict_cache(pending_reqs.pop_front()));
            idle_cycles = 0;
         end
         if ((!req_tvalid || req_tready) ) begin
            if (pending_reqs.size() > 0 && !hold_req && !roll_idle()) begin
               req_tvalid <= 1'b1;
               req_tdata <= {3'b000, pending_reqs[0].decode_ok,
                             pending_reqs[0].entry_handle,
                             pending_reqs[0].entry_size, pending_reqs[0].key_lo,
                             pending_reqs[0].key_hi};
               req_tuser <= pending_reqs[0].mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cache_rsp_type got, exp_rsp;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            got.entry_count = rsp_tdata[79:73];
            got.total_bytes = rsp_tdata[72:40];
            got.evicted_count = rsp_tdata[39:33];
            got.found_handle = rsp_tdata[32:1];
            got.hit = rsp_tdata[0];
            if (expected_rsps.size() == 0) begin
               $error("unexpected response transaction");
               failed = 1'b1;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (got.hit !== exp_rsp.hit) begin
                  $error("hit exp %0h got %0h", exp_rsp.hit, got.hit);
                  failed = 1'b1;
               end
               if (got.found_handle !== exp_rsp.found_handle) begin
                  $error("found_handle exp %0h got %0h", exp_rsp.found_handle,
                         got.found_handle);
                  failed = 1'b1;
               end
               if (got.evicted_count !== exp_rsp.evicted_count) begin
                  $error("evicted_count exp %0d got %0d", exp_rsp.evicted_count,
                         got.evicted_count);
                  failed = 1'b1;
               end
               if (got.total_bytes !== exp_rsp.total_bytes) begin
                  $error("total_bytes exp %0d got %0d", exp_rsp.total_bytes,
                         got.total_bytes);
                  failed = 1'b1;
               end
               if (got.entry_count !== exp_rsp.entry_count) begin
                  $error("entry_count exp %0d got %0d", exp_rsp.entry_count,
                         got.entry_count);
                  failed = 1'b1;
               end
            end
         end
         rsp_tready <= !roll_idle();
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (!reset) begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("fifo_byte_budget_cache verification failed");
            $finish;
         end
      end
   end

   function automatic cache_req_type rand_req(int unsigned size_max);
      cache_req_type r;
      int unsigned pick;
      r.key_hi = {$urandom, $urandom};
      r.key_lo = {$urandom, $urandom};
      if (used_his.size() > 0 && $urandom_range(99) < 45) begin
         pick = $urandom_range(used_his.size() - 1);
         r.key_hi = used_his[pick];
         r.key_lo = used_los[pick];
      end else if ($urandom_range(9) == 0) begin
         r.key_hi = 64'($urandom_range(3));
         r.key_lo = 64'($urandom_range(3));
      end
      r.mode = ($urandom_range(99) < 40) ? fbbc_pkg::MODE_LOOKUP : fbbc_pkg::MODE_INSERT;
      r.entry_size = 28'(($urandom_range(19) == 0) ? $urandom : $urandom_range(size_max));
      r.entry_handle = $urandom;
      r.decode_ok = ($urandom_range(9) != 0);
      if (r.mode == fbbc_pkg::MODE_INSERT) begin
         used_his.push_back(r.key_hi);
         used_los.push_back(r.key_lo);
         if (used_his.size() > 200) begin
            void'(used_his.pop_front());
            void'(used_los.pop_front());
         end
      end
      return r;
   endfunction

   function automatic cache_req_type mk(logic mode, logic [63:0] hi, logic [63:0] lo,
                                        logic [27:0] size, logic [31:0] handle, logic ok);
      cache_req_type r;
      r.mode = mode;
      r.key_hi = hi;
      r.key_lo = lo;
      r.entry_size = size;
      r.entry_handle = handle;
      r.decode_ok = ok;
      return r;
   endfunction

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] value);
      drain();
      csr_wdata <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sh_limit = value;
      idle_cycles = 0;
   endtask

   task automatic run_random(int unsigned n, int unsigned size_max);
      for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req(size_max));
   endtask

   initial begin
      sh_limit = fbbc_pkg::LIMIT_RESET;
      for (int i = 0; i < NSLOT; i++) sh_valid[i] = 1'b0;
      sh_head = 0;
      sh_count = 0;
      sh_total = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, duplicate, failed decode, lookup hit and miss
      pending_reqs.push_back(mk(fbbc_pkg::MODE_LOOKUP, '0, '0, '0, '0, 1'b0));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, '0, '0, '0, '0, 1'b1));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, '1, '1, 28'hFFFFFFF, '1, 1'b1));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_LOOKUP, '1, '1, '1, '0, 1'b0));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, '1, '1, 28'd5, 32'h1234, 1'b1));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, 64'h55, 64'hAA, 28'd7, 32'h77, 1'b0));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, '0, '0, 28'd9, 32'h9, 1'b0));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_LOOKUP, 64'h55, 64'hAA, '0, '1, 1'b1));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, 64'h1, '0, 28'd60000000, 32'hA, 1'b1));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, '0, 64'h1, 28'd50000000, 32'hB, 1'b1));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_LOOKUP, 64'h1, '0, '0, '0, 1'b1));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_LOOKUP, '0, 64'h1, '0, '0, 1'b1));

      // full table: 70 small inserts with a huge limit
      write_limit(32'hFFFFFFFF);
      for (int i = 0; i < 70; i++)
         pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, 64'hC0DE, 64'(i), 28'(i + 1),
                                   32'(i), 1'b1));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_LOOKUP, 64'hC0DE, 64'd3, '0, '0, 1'b0));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_LOOKUP, 64'hC0DE, 64'd69, '0, '0, 1'b0));
      // lowered limit takes effect only on the next new insert
      write_limit(32'd1000);
      pending_reqs.push_back(mk(fbbc_pkg::MODE_LOOKUP, 64'hC0DE, 64'd69, '0, '0, 1'b0));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, 64'hC0DE, 64'd69, 28'd1, '0, 1'b1));
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, 64'hBEEF, 64'd0, 28'd1, 32'h5, 1'b1));
      write_limit(32'd0);
      pending_reqs.push_back(mk(fbbc_pkg::MODE_INSERT, 64'hBEEF, 64'd1, 28'd0, 32'h6, 1'b1));

      // random phases across limits
      write_limit(32'd1);
      run_random(100, 3);
      write_limit(32'd2000);
      run_random(250, 100);
      write_limit(fbbc_pkg::LIMIT_RESET);
      no_idle = 1'b1;
      run_random(150, 5000000);
      drain();
      no_idle = 1'b0;
      write_limit(32'hFFFFFFFF);
      run_random(300, 28'hFFFFFFF);
      // pause until the cache has answered everything
      hold_req = 1'b1;
      while (expected_rsps.size() > 0 || req_tvalid) @(posedge clock);
      hold_req = 1'b0;
      write_limit(32'd700);
      run_random(250, 60);
      drain();

      if (!failed) begin
         $display("fifo_byte_budget_cache verification clean");
      end else begin
         $display("fifo_byte_budget_cache verification failed");
      end
      $finish;
   end
endmodule

// File: filelist.f
hw/rtl/fbbc_pkg.sv
hw/rtl/fbbc_cell.sv
hw/rtl/fifo_byte_budget_cache.sv
dv/tb_top.sv
